FILE: rtl/phr_pkg.sv
// Shared types and constants for the PPG heart-rate detector.
`timescale 1ns / 1ps
package phr_pkg;
    localparam logic [2:0] CFG_ENTER   = 3'd0;
    localparam logic [2:0] CFG_EXIT    = 3'd1;
    localparam logic [2:0] CFG_PNEED   = 3'd2;
    localparam logic [2:0] CFG_ANEED   = 3'd3;
    localparam logic [2:0] CFG_PFLOOR  = 3'd4;
    localparam logic [2:0] CFG_SFLOOR  = 3'd5;
    localparam logic [2:0] CFG_MINIV   = 3'd6;
    localparam logic [2:0] CFG_MAXIV   = 3'd7;

    // divider request / answer between the top level and the serial divider
    typedef struct packed {
        logic        start;
        logic [31:0] num;
        logic [31:0] den;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [31:0] quo;
    } t_div_rsp;
endpackage

FILE: rtl/ppg_heart_rate_detector.sv
// PPG heart-rate detector top level.
`timescale 1ns / 1ps
// Usage:
//  s_axis carries one raw IR sample per transfer (tdata[17:0]).
//  m_axis returns one result per sample; tdata from bit 0 up: finger_present,
//  finger_changed, bpm_valid, bpm_value[15:0], ir_level_out[17:0].
//  Configuration is written through i_cfg_we / i_cfg_addr / i_cfg_data while idle.
//  Samples are handled one at a time: each passes the level, filter, AC, magnitude
//  and peak states before its result is registered (with the finger off it goes from
//  the filter state straight to output); s_axis is ready again in the cycle after that.
//  A beat inside the interval range runs the serial divider for the rate; if the
//  rate passes the jump test a second division forms the average.
//  s_axis_tready is high only in the idle state. A stalled receiver holds its
//  result in the output register; the next sample is still processed and then
//  waits, so the input stalls once two samples are held.
//  Reset clears all filter state and loads the default configuration.
module ppg_heart_rate_detector #(
    parameter int BPM_WINDOW     = 8,
    parameter int SAMPLE_RATE    = 100,
    parameter int BPM_JUMP_LIMIT = 20,
    parameter int DC_SHIFT       = 5,
    parameter int SMOOTH_SHIFT   = 2,
    parameter int LEVEL_SHIFT    = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // ir_sample[17:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // present, changed, bpm_valid, bpm[15:0], level[17:0]
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [25:0] i_cfg_data
);
    localparam int HW = (BPM_WINDOW > 1) ? $clog2(BPM_WINDOW) : 1;
    localparam int CW = $clog2(BPM_WINDOW + 1);
    localparam int SW = 16 + HW;        // sum of up to BPM_WINDOW 16-bit rates
    localparam logic [31:0] RATE_NUM = 32'(60 * SAMPLE_RATE * 256);
    localparam logic [31:0] JUMP = 32'(BPM_JUMP_LIMIT * 256);

    localparam logic [3:0] S_IDLE = 4'd0, S_LVL = 4'd1, S_FLT = 4'd2, S_AC = 4'd3,
        S_MAG = 4'd4, S_PEAK = 4'd5, S_DIV1 = 4'd6, S_JMP = 4'd7, S_DIV2 = 4'd8,
        S_OUT = 4'd9;

    logic [3:0]  r_state;
    logic [17:0] r_enter, r_exit;
    logic [7:0]  r_pneed, r_aneed;
    logic [25:0] r_pfloor, r_sfloor;
    logic [11:0] r_miniv, r_maxiv;

    logic signed [31:0] r_x, r_lvl, r_dc, r_ac, r_mag;
    logic signed [31:0] r_win [3];
    logic [1:0]  r_fill, r_slot;
    logic        r_on, r_chg, r_lpv, r_lrv, r_bv;
    logic [7:0]  r_prun, r_arun;
    logic [31:0] r_cnt, r_lps;
    logic [15:0] r_hist [BPM_WINDOW];
    logic [CW-1:0] r_rcnt;
    logic [HW-1:0] r_rslot;
    logic [SW-1:0] r_sum;
    logic [15:0] r_lrate, r_bpm, r_rate;
    logic        r_ovalid;
    logic [39:0] r_odata;

    phr_pkg::t_div_req n_req;
    phr_pkg::t_div_rsp w_rsp;

    phr_divider u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(n_req), .o_rsp(w_rsp));

    function automatic logic signed [31:0] filt(logic signed [31:0] x,
                                                logic signed [31:0] t, int sh);
        logic signed [31:0] d;
        d = t - x;
        return x + (d >>> sh);
    endfunction

    // combinational helpers
    logic signed [31:0] w_lvl, w_dc, w_ac, w_sac, w_abs, w_mag;
    logic signed [31:0] w_a, w_b, w_c, w_dyn, w_m3;
    logic [31:0] w_iv;
    logic        w_pk, w_peak, w_inr, w_beat, w_take, w_full;
    logic        w_enter, w_leave, w_on_nx, w_out_go;
    logic [31:0] w_d;
    logic [HW-1:0] w_s;
    logic [CW-1:0] w_ncnt;
    logic [SW-1:0] w_nsum;

    always_comb begin
        w_lvl = filt(r_lvl, r_x, LEVEL_SHIFT);
        w_dc  = filt(r_dc, r_x, DC_SHIFT);
        w_ac  = r_x - r_dc;
        w_sac = filt(r_ac, w_ac, SMOOTH_SHIFT);
        w_abs = r_ac[31] ? -r_ac : r_ac;
        w_mag = filt(r_mag, w_abs, LEVEL_SHIFT);
        w_enter = !r_on && (r_prun >= r_pneed);
        w_leave = r_on && (r_arun >= r_aneed);
        w_on_nx = w_enter || (r_on && !w_leave);
        w_a = r_win[r_slot];
        w_b = r_win[(r_slot == 2'd2) ? 2'd0 : r_slot + 2'd1];
        w_c = r_win[(r_slot == 2'd0) ? 2'd2 : r_slot - 2'd1];
        // 3*m/5 with m >= 0: reciprocal multiply, exact for m < 2^28
        w_m3 = 32'((64'(r_mag) * 64'd3 * 64'd858993460) >> 32);
        w_dyn = (w_m3 < $signed({6'd0, r_pfloor})) ? $signed({6'd0, r_pfloor}) : w_m3;
        w_pk = (w_b > w_a) && (w_b > w_c) && ((w_b - w_a) > $signed({6'd0, r_sfloor}))
            && ((w_b - w_c) > $signed({6'd0, r_sfloor})) && (w_b > w_dyn);
        w_peak = (r_fill == 2'd3) && w_pk;
        w_iv = r_cnt - r_lps;
        w_inr = (w_iv >= {20'd0, r_miniv}) && (w_iv <= {20'd0, r_maxiv});
        w_beat = w_peak && r_lpv && w_inr;
        w_d  = ({16'd0, r_rate} > {16'd0, r_lrate}) ? {16'd0, r_rate - r_lrate}
                                                    : {16'd0, r_lrate - r_rate};
        w_take = !(r_lrv && (w_d > JUMP));
        w_s  = r_rslot;
        w_full = r_rcnt >= CW'(BPM_WINDOW);
        w_ncnt = w_full ? r_rcnt : r_rcnt + CW'(1);
        w_nsum = w_full ? r_sum - SW'(r_hist[w_s]) + SW'(r_rate)
                        : r_sum + SW'(r_rate);
        w_out_go = (r_state == S_OUT) && (!r_ovalid || m_axis_tready);
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    always_comb begin
        n_req.start = 1'b0;
        n_req.num = RATE_NUM;
        n_req.den = w_iv;
        if (r_state == S_PEAK && w_beat && w_iv != 32'd0)
            n_req.start = 1'b1;
        if (r_state == S_JMP && w_take) begin
            n_req.start = 1'b1;
            n_req.num = 32'(w_nsum);
            n_req.den = 32'(w_ncnt);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_enter <= 18'd50000; r_exit <= 18'd30000;
            r_pneed <= 8'd10; r_aneed <= 8'd10;
            r_pfloor <= 26'd5120; r_sfloor <= 26'd256;
            r_miniv <= 12'd30; r_maxiv <= 12'd150;
            r_lvl <= '0; r_dc <= '0; r_ac <= '0; r_mag <= '0;
            r_on <= 1'b0; r_prun <= '0; r_arun <= '0;
            r_fill <= '0; r_slot <= '0; r_cnt <= '0; r_lps <= '0;
            r_lpv <= 1'b0; r_rcnt <= '0; r_rslot <= '0; r_sum <= '0;
            r_lrate <= '0; r_lrv <= 1'b0; r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    phr_pkg::CFG_ENTER:  r_enter  <= i_cfg_data[17:0];
                    phr_pkg::CFG_EXIT:   r_exit   <= i_cfg_data[17:0];
                    phr_pkg::CFG_PNEED:  r_pneed  <= i_cfg_data[7:0];
                    phr_pkg::CFG_ANEED:  r_aneed  <= i_cfg_data[7:0];
                    phr_pkg::CFG_PFLOOR: r_pfloor <= i_cfg_data;
                    phr_pkg::CFG_SFLOOR: r_sfloor <= i_cfg_data;
                    phr_pkg::CFG_MINIV:  r_miniv  <= i_cfg_data[11:0];
                    phr_pkg::CFG_MAXIV:  r_maxiv  <= i_cfg_data[11:0];
                    default: ;
                endcase
            end
            if (w_out_go) r_ovalid <= 1'b1;
            else if (m_axis_tready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_x <= $signed({6'd0, s_axis_tdata[17:0], 8'd0});
                        r_cnt <= r_cnt + 32'd1;
                        r_chg <= 1'b0; r_bv <= 1'b0; r_bpm <= '0;
                        r_state <= S_LVL;
                    end
                end
                S_LVL: begin
                    r_lvl <= w_lvl;
                    if (w_lvl >= $signed({6'd0, r_enter, 8'd0})) begin
                        if (r_prun != 8'hFF) r_prun <= r_prun + 8'd1;
                        r_arun <= '0;
                    end else if (w_lvl <= $signed({6'd0, r_exit, 8'd0})) begin
                        if (r_arun != 8'hFF) r_arun <= r_arun + 8'd1;
                        r_prun <= '0;
                    end
                    r_state <= S_FLT;
                end
                S_FLT: begin
                    if (w_enter) begin
                        r_on <= 1'b1; r_arun <= '0; r_chg <= 1'b1;
                    end else if (w_leave) begin
                        r_on <= 1'b0; r_prun <= '0; r_chg <= 1'b1;
                    end
                    // finger coming on, or finger off: beat state starts over
                    if (w_enter || !w_on_nx) begin
                        r_fill <= '0; r_slot <= '0; r_lpv <= 1'b0;
                        r_rcnt <= '0; r_rslot <= '0; r_sum <= '0;
                        r_lrate <= '0; r_lrv <= 1'b0;
                    end
                    if (w_on_nx) begin
                        r_dc <= w_enter ? r_x : w_dc;
                        if (w_enter) r_ac <= '0;
                        r_state <= S_AC;
                    end else begin
                        r_dc <= r_x; r_ac <= '0; r_mag <= '0;
                        r_state <= S_OUT;
                    end
                end
                S_AC: begin
                    r_ac <= w_sac;
                    r_win[r_slot] <= w_sac;
                    r_slot <= (r_slot == 2'd2) ? 2'd0 : r_slot + 2'd1;
                    if (r_fill != 2'd3) r_fill <= r_fill + 2'd1;
                    r_state <= S_MAG;
                end
                S_MAG: begin
                    r_mag <= w_mag;
                    r_state <= S_PEAK;
                end
                S_PEAK: begin
                    if (w_peak) begin
                        r_lpv <= 1'b1;
                        if (!r_lpv || w_inr || w_iv > {20'd0, r_maxiv}) r_lps <= r_cnt;
                    end
                    if (w_beat && w_iv == 32'd0) r_rate <= 16'hFFFF;
                    if (w_beat) r_state <= (w_iv == 32'd0) ? S_JMP : S_DIV1;
                    else r_state <= S_OUT;
                end
                S_DIV1: begin
                    if (w_rsp.done) begin
                        r_rate <= (|w_rsp.quo[31:16]) ? 16'hFFFF : w_rsp.quo[15:0];
                        r_state <= S_JMP;
                    end
                end
                S_JMP: begin
                    if (w_take) begin
                        r_hist[w_s] <= r_rate;
                        r_sum <= w_nsum;
                        r_rcnt <= w_ncnt;
                        r_rslot <= (w_s == HW'(BPM_WINDOW - 1)) ? '0 : w_s + HW'(1);
                        r_state <= S_DIV2;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_DIV2: begin
                    if (w_rsp.done) begin
                        r_lrate <= w_rsp.quo[15:0]; r_lrv <= 1'b1;
                        r_bv <= 1'b1; r_bpm <= w_rsp.quo[15:0];
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_go) begin
                        r_odata <= {3'd0, r_lvl[25:8], r_bpm, r_bv, r_chg, r_on};
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: rtl/phr_divider.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module phr_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  phr_pkg::t_div_req i_req,
    output phr_pkg::t_div_rsp o_rsp
);
    logic [31:0] r_quo, r_den;
    logic [32:0] r_rem;
    logic [5:0]  r_cnt;
    logic        r_busy, r_done;
    logic [32:0] n_rem;
    logic [32:0] n_try;

    always_comb begin
        n_rem = {r_rem[31:0], r_quo[31]};
        n_try = n_rem - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_quo  <= i_req.num;
                r_den  <= i_req.den;
                r_rem  <= '0;
                r_cnt  <= 6'd32;
            end else if (r_busy) begin
                if (!n_try[32]) begin
                    r_rem <= n_try;
                    r_quo <= {r_quo[30:0], 1'b1};
                end else begin
                    r_rem <= n_rem;
                    r_quo <= {r_quo[30:0], 1'b0};
                end
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
endmodule
